### hw/rtl/kmode_pkg.sv
// kmode_pkg: shared types, constants, fixed-point helpers and the step microprogram
// used by the interfaces, the arithmetic unit and the top level; depends on nothing
package kmode_pkg;

    localparam int WORD_BITS = 64;
    localparam int FRAC_BITS = 40;
    localparam int HALF_BITS = WORD_BITS / 2;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int EXT_BITS  = WORD_BITS + 2;
    localparam int STEP_BITS = WORD_BITS - 1;
    localparam int ERR_BITS  = WORD_BITS - 1;
    localparam int DIV_STEPS = WORD_BITS / 4;
    localparam int REM_BITS  = 3;
    localparam int PC_BITS   = 7;
    localparam int SEL_BITS  = 5;
    localparam int TEMP_REGS = 16;
    localparam int TEMP_BITS = 4;
    localparam int CFG_BITS  = 3;

    typedef logic [WORD_BITS-1:0] t_word;

    localparam t_word WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // register reset values
    localparam logic [STEP_BITS-1:0] RST_STEP = STEP_BITS'(64'd1099512);
    localparam t_word RST_CII = t_word'(-64'sd219902325555200);
    localparam t_word RST_CIV = t_word'(-64'sd21990232555520);
    localparam t_word RST_CIB = t_word'(64'sd2199023255552000);
    localparam t_word RST_CVI = t_word'(64'sd54975581388800000);
    localparam t_word RST_CVV = t_word'(-64'sd610839793208889);

    // configuration register indexes
    localparam logic [CFG_BITS-1:0] CFG_STEP = 3'd0;
    localparam logic [CFG_BITS-1:0] CFG_CII  = 3'd1;
    localparam logic [CFG_BITS-1:0] CFG_CIV  = 3'd2;
    localparam logic [CFG_BITS-1:0] CFG_CIB  = 3'd3;
    localparam logic [CFG_BITS-1:0] CFG_CVI  = 3'd4;
    localparam logic [CFG_BITS-1:0] CFG_CVV  = 3'd5;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // arithmetic unit operations
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_SCL = 3'd3;
    localparam logic [2:0] OP_FIF = 3'd4;

    // operand and destination selects: scratch entries below 16, named words from 16 up
    localparam logic [SEL_BITS-1:0] R_A   = 5'd0;
    localparam logic [SEL_BITS-1:0] R_B   = 5'd1;
    localparam logic [SEL_BITS-1:0] R_K1  = 5'd2;
    localparam logic [SEL_BITS-1:0] R_L1  = 5'd3;
    localparam logic [SEL_BITS-1:0] R_KX  = 5'd4;
    localparam logic [SEL_BITS-1:0] R_LX  = 5'd5;
    localparam logic [SEL_BITS-1:0] R_K4  = 5'd6;
    localparam logic [SEL_BITS-1:0] R_L4  = 5'd7;
    localparam logic [SEL_BITS-1:0] R_WI  = 5'd8;
    localparam logic [SEL_BITS-1:0] R_ZI  = 5'd9;
    localparam logic [SEL_BITS-1:0] R_DW  = 5'd10;
    localparam logic [SEL_BITS-1:0] R_DZ  = 5'd11;
    localparam logic [SEL_BITS-1:0] R_H   = 5'd16;
    localparam logic [SEL_BITS-1:0] R_CII = 5'd17;
    localparam logic [SEL_BITS-1:0] R_CIV = 5'd18;
    localparam logic [SEL_BITS-1:0] R_CIB = 5'd19;
    localparam logic [SEL_BITS-1:0] R_CVI = 5'd20;
    localparam logic [SEL_BITS-1:0] R_CVV = 5'd21;
    localparam logic [SEL_BITS-1:0] R_CUR = 5'd22;
    localparam logic [SEL_BITS-1:0] R_VOL = 5'd23;
    localparam logic [SEL_BITS-1:0] R_CCI = 5'd24;
    localparam logic [SEL_BITS-1:0] R_CCV = 5'd25;
    localparam logic [SEL_BITS-1:0] R_TIM = 5'd26;
    localparam logic [SEL_BITS-1:0] R_EI  = 5'd27;
    localparam logic [SEL_BITS-1:0] R_EV  = 5'd28;

    localparam logic [PC_BITS-1:0] PROG_LAST = 7'd93;

    typedef struct packed {
        logic [2:0]          op;
        logic [SEL_BITS-1:0] dst;
        logic [SEL_BITS-1:0] sa;
        logic [SEL_BITS-1:0] sb;
        logic [1:0]          p;
        logic [3:0]          d;
    } t_uop;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
        logic [1:0] p;
        logic [3:0] d;
    } t_alu_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_sts;

    function automatic t_word mag(input t_word x);
        return x[WORD_BITS-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic t_word from_mag(input logic neg, input logic [EXT_BITS-1:0] m);
        t_word r;
        if (!neg) begin
            r = (m > EXT_BITS'(WMAX)) ? WMAX : m[WORD_BITS-1:0];
        end else if (m == '0) begin
            r = '0;
        end else if (m > EXT_BITS'(WMIN)) begin
            r = WMIN;
        end else begin
            r = ~m[WORD_BITS-1:0] + 1'b1;
        end
        return r;
    endfunction

    function automatic t_word sat_sum(input logic [WORD_BITS:0] s);
        t_word r;
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            r = s[WORD_BITS] ? WMIN : WMAX;
        end else begin
            r = s[WORD_BITS-1:0];
        end
        return r;
    endfunction

    // one radix-16 digit of a division by a small constant: {quotient digit, remainder}
    function automatic logic [REM_BITS+3:0] div_digit(input logic [REM_BITS+3:0] t,
                                                       input logic [3:0] d);
        logic [3:0]  q;
        logic [7:0]  qd;
        q  = '0;
        for (int i = 1; i < 16; i++) begin
            if (11'(t) >= 11'(i) * 11'(d)) q = 4'(i);
        end
        qd = 8'(q) * 8'(d);
        return {q, REM_BITS'(t - qd[REM_BITS+3:0])};
    endfunction

    // (2*r*p + d) / (2*d) for a remainder r below d
    function automatic logic [1:0] round_term(input logic [REM_BITS-1:0] r,
                                              input logic [1:0] p, input logic [3:0] d);
        logic [6:0] n;
        logic [1:0] rt;
        n  = 7'(7'(r) * 7'(p) * 7'd2 + 7'(d));
        rt = '0;
        for (int i = 1; i < 4; i++) begin
            if (9'(n) >= 9'(2 * i) * 9'(d)) rt = 2'(i);
        end
        return rt;
    endfunction

    function automatic t_uop uop(input logic [2:0] op, input logic [SEL_BITS-1:0] dst,
                                 input logic [SEL_BITS-1:0] sa, input logic [SEL_BITS-1:0] sb,
                                 input logic [1:0] p, input logic [3:0] d);
        t_uop u;
        u.op  = op;
        u.dst = dst;
        u.sa  = sa;
        u.sb  = sb;
        u.p   = p;
        u.d   = d;
        return u;
    endfunction

    // one stage: k = h*di/dt(x, y), l = h*dv/dt(x, y)
    function automatic t_uop stage_uop(input logic [3:0] i, input logic [SEL_BITS-1:0] x,
                                       input logic [SEL_BITS-1:0] y,
                                       input logic [SEL_BITS-1:0] k,
                                       input logic [SEL_BITS-1:0] l);
        t_uop u;
        case (i)
            4'd0:    u = uop(OP_MUL, R_A, R_CII, x, 2'd0, 4'd0);
            4'd1:    u = uop(OP_MUL, R_B, R_CIV, y, 2'd0, 4'd0);
            4'd2:    u = uop(OP_ADD, R_A, R_A, R_B, 2'd0, 4'd0);
            4'd3:    u = uop(OP_ADD, R_A, R_A, R_CIB, 2'd0, 4'd0);
            4'd4:    u = uop(OP_MUL, k, R_H, R_A, 2'd0, 4'd0);
            4'd5:    u = uop(OP_MUL, R_A, R_CVI, x, 2'd0, 4'd0);
            4'd6:    u = uop(OP_MUL, R_B, R_CVV, y, 2'd0, 4'd0);
            4'd7:    u = uop(OP_ADD, R_A, R_A, R_B, 2'd0, 4'd0);
            4'd8:    u = uop(OP_MUL, l, R_H, R_A, 2'd0, 4'd0);
            default: u = uop(OP_ADD, R_A, R_A, R_B, 2'd0, 4'd0);
        endcase
        return u;
    endfunction

    function automatic t_uop prog_rom(input logic [PC_BITS-1:0] pc);
        t_uop u;
        if (pc <= 7'd8) begin
            u = stage_uop(pc[3:0], R_CUR, R_VOL, R_K1, R_L1);
        end else if (pc inside {[7'd13:7'd21]}) begin
            u = stage_uop(4'(pc - 7'd13), R_WI, R_ZI, R_KX, R_LX);
        end else if (pc inside {[7'd30:7'd38]}) begin
            u = stage_uop(4'(pc - 7'd30), R_WI, R_ZI, R_KX, R_LX);
        end else if (pc inside {[7'd47:7'd55]}) begin
            u = stage_uop(4'(pc - 7'd47), R_WI, R_ZI, R_K4, R_L4);
        end else if (pc inside {[7'd68:7'd76]}) begin
            u = stage_uop(4'(pc - 7'd68), R_WI, R_ZI, R_KX, R_LX);
        end else begin
            case (pc)
                7'd9:    u = uop(OP_SCL, R_A, R_K1, R_A, 2'd1, 4'd3);
                7'd10:   u = uop(OP_ADD, R_WI, R_CUR, R_A, 2'd0, 4'd0);
                7'd11:   u = uop(OP_SCL, R_A, R_L1, R_A, 2'd1, 4'd3);
                7'd12:   u = uop(OP_ADD, R_ZI, R_VOL, R_A, 2'd0, 4'd0);
                7'd22:   u = uop(OP_SCL, R_A, R_K1, R_A, 2'd1, 4'd6);
                7'd23:   u = uop(OP_ADD, R_WI, R_CUR, R_A, 2'd0, 4'd0);
                7'd24:   u = uop(OP_SCL, R_A, R_KX, R_A, 2'd1, 4'd6);
                7'd25:   u = uop(OP_ADD, R_WI, R_WI, R_A, 2'd0, 4'd0);
                7'd26:   u = uop(OP_SCL, R_A, R_L1, R_A, 2'd1, 4'd6);
                7'd27:   u = uop(OP_ADD, R_ZI, R_VOL, R_A, 2'd0, 4'd0);
                7'd28:   u = uop(OP_SCL, R_A, R_LX, R_A, 2'd1, 4'd6);
                7'd29:   u = uop(OP_ADD, R_ZI, R_ZI, R_A, 2'd0, 4'd0);
                7'd39:   u = uop(OP_SCL, R_A, R_K1, R_A, 2'd1, 4'd8);
                7'd40:   u = uop(OP_ADD, R_WI, R_CUR, R_A, 2'd0, 4'd0);
                7'd41:   u = uop(OP_SCL, R_A, R_KX, R_A, 2'd3, 4'd8);
                7'd42:   u = uop(OP_ADD, R_WI, R_WI, R_A, 2'd0, 4'd0);
                7'd43:   u = uop(OP_SCL, R_A, R_L1, R_A, 2'd1, 4'd8);
                7'd44:   u = uop(OP_ADD, R_ZI, R_VOL, R_A, 2'd0, 4'd0);
                7'd45:   u = uop(OP_SCL, R_A, R_LX, R_A, 2'd3, 4'd8);
                7'd46:   u = uop(OP_ADD, R_ZI, R_ZI, R_A, 2'd0, 4'd0);
                7'd56:   u = uop(OP_SCL, R_A, R_K1, R_A, 2'd1, 4'd2);
                7'd57:   u = uop(OP_SCL, R_B, R_KX, R_A, 2'd3, 4'd2);
                7'd58:   u = uop(OP_SUB, R_A, R_A, R_B, 2'd0, 4'd0);
                7'd59:   u = uop(OP_ADD, R_A, R_A, R_K4, 2'd0, 4'd0);
                7'd60:   u = uop(OP_ADD, R_DW, R_A, R_K4, 2'd0, 4'd0);
                7'd61:   u = uop(OP_SCL, R_A, R_L1, R_A, 2'd1, 4'd2);
                7'd62:   u = uop(OP_SCL, R_B, R_LX, R_A, 2'd3, 4'd2);
                7'd63:   u = uop(OP_SUB, R_A, R_A, R_B, 2'd0, 4'd0);
                7'd64:   u = uop(OP_ADD, R_A, R_A, R_L4, 2'd0, 4'd0);
                7'd65:   u = uop(OP_ADD, R_DZ, R_A, R_L4, 2'd0, 4'd0);
                7'd66:   u = uop(OP_ADD, R_WI, R_CUR, R_DW, 2'd0, 4'd0);
                7'd67:   u = uop(OP_ADD, R_ZI, R_VOL, R_DZ, 2'd0, 4'd0);
                7'd77:   u = uop(OP_SCL, R_A, R_K1, R_A, 2'd1, 4'd6);
                7'd78:   u = uop(OP_SCL, R_B, R_K4, R_A, 2'd2, 4'd3);
                7'd79:   u = uop(OP_ADD, R_A, R_A, R_B, 2'd0, 4'd0);
                7'd80:   u = uop(OP_SCL, R_B, R_KX, R_A, 2'd1, 4'd6);
                7'd81:   u = uop(OP_ADD, R_A, R_A, R_B, 2'd0, 4'd0);
                7'd82:   u = uop(OP_ADD, R_CUR, R_CUR, R_A, 2'd0, 4'd0);
                7'd83:   u = uop(OP_SCL, R_A, R_L1, R_A, 2'd1, 4'd6);
                7'd84:   u = uop(OP_SCL, R_B, R_L4, R_A, 2'd2, 4'd3);
                7'd85:   u = uop(OP_ADD, R_A, R_A, R_B, 2'd0, 4'd0);
                7'd86:   u = uop(OP_SCL, R_B, R_LX, R_A, 2'd1, 4'd6);
                7'd87:   u = uop(OP_ADD, R_A, R_A, R_B, 2'd0, 4'd0);
                7'd88:   u = uop(OP_ADD, R_VOL, R_VOL, R_A, 2'd0, 4'd0);
                7'd89:   u = uop(OP_ADD, R_CCI, R_CCI, R_DW, 2'd0, 4'd0);
                7'd90:   u = uop(OP_ADD, R_CCV, R_CCV, R_DZ, 2'd0, 4'd0);
                7'd91:   u = uop(OP_ADD, R_TIM, R_TIM, R_H, 2'd0, 4'd0);
                7'd92:   u = uop(OP_FIF, R_EI, R_CCI, R_CUR, 2'd0, 4'd5);
                7'd93:   u = uop(OP_FIF, R_EV, R_CCV, R_VOL, 2'd0, 4'd5);
                default: u = uop(OP_ADD, R_A, R_A, R_B, 2'd0, 4'd0);
            endcase
        end
        return u;
    endfunction

endpackage

### hw/rtl/kmode_in_if.sv
// kmode_in_if: input item channel, valid/ready with load or step payload
// depends on kmode_pkg
interface kmode_in_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    kind;
    logic signed [kmode_pkg::WORD_BITS-1:0]  start_time;
    logic signed [kmode_pkg::WORD_BITS-1:0]  init_current;
    logic signed [kmode_pkg::WORD_BITS-1:0]  init_voltage;

    modport source (output valid, kind, start_time, init_current, init_voltage, input ready);
    modport sink (input valid, kind, start_time, init_current, init_voltage, output ready);
endinterface

### hw/rtl/kmode_out_if.sv
// kmode_out_if: result channel, valid/ready with time, states and error estimates
// depends on kmode_pkg
interface kmode_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [kmode_pkg::WORD_BITS-1:0]  time_now;
    logic signed [kmode_pkg::WORD_BITS-1:0]  current_now;
    logic signed [kmode_pkg::WORD_BITS-1:0]  voltage_now;
    logic [kmode_pkg::ERR_BITS-1:0]          current_error;
    logic [kmode_pkg::ERR_BITS-1:0]          voltage_error;

    modport source (output valid, time_now, current_now, voltage_now, current_error,
                    voltage_error, input ready);
    modport sink (input valid, time_now, current_now, voltage_now, current_error,
                  voltage_error, output ready);
endinterface

### hw/rtl/kmode_alu.sv
// kmode_alu: shared multi-cycle fixed-point unit: saturating add/sub, rounded multiply
// from 32x32 partial products, scaling by p/d and fifth of a gap by radix-16 digits; uses kmode_pkg
module kmode_alu (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kmode_pkg::t_alu_cmd  i_cmd,
    input  kmode_pkg::t_word     i_opa,
    input  kmode_pkg::t_word     i_opb,
    output kmode_pkg::t_alu_sts  o_sts,
    output kmode_pkg::t_word     o_result
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_RND  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam int W = kmode_pkg::WORD_BITS;
    localparam int F = kmode_pkg::FRAC_BITS;
    localparam int R = kmode_pkg::REM_BITS;

    logic [2:0]                          r_state;
    logic [3:0]                          r_cnt;
    logic [2:0]                          r_op;
    logic [1:0]                          r_p;
    logic [3:0]                          r_d;
    logic                                r_neg;
    kmode_pkg::t_word                    r_ma, r_mb, r_quo, r_result;
    logic [kmode_pkg::PROD_BITS-1:0]     r_acc;
    logic [W:0]                          r_sum;
    logic [R-1:0]                        r_rem;
    logic                                r_done;

    logic [W:0]                          sum_ab, dif_ab, dif_mag;
    kmode_pkg::t_word                    start_ma;
    logic [kmode_pkg::HALF_BITS-1:0]     pa, pb;
    logic [W-1:0]                        pp;
    logic [1:0]                          sh;
    logic [kmode_pkg::PROD_BITS-1:0]     pp_shift;
    logic [R+3:0]                        digit;
    logic [kmode_pkg::EXT_BITS-1:0]      qp;
    kmode_pkg::t_word                    q5, fin;

    always_comb begin
        sum_ab  = {i_opa[W-1], i_opa} + {i_opb[W-1], i_opb};
        dif_ab  = {i_opa[W-1], i_opa} - {i_opb[W-1], i_opb};
        dif_mag = dif_ab[W] ? (~dif_ab + 1'b1) : dif_ab;
        start_ma = (i_cmd.op == kmode_pkg::OP_FIF) ? dif_mag[W-1:0] : kmode_pkg::mag(i_opa);
    end

    // partial product of the selected halves
    always_comb begin
        pa       = r_cnt[0] ? r_ma[W-1:kmode_pkg::HALF_BITS] : r_ma[kmode_pkg::HALF_BITS-1:0];
        pb       = r_cnt[1] ? r_mb[W-1:kmode_pkg::HALF_BITS] : r_mb[kmode_pkg::HALF_BITS-1:0];
        pp       = W'(pa) * W'(pb);
        sh       = 2'(r_cnt[0]) + 2'(r_cnt[1]);
        pp_shift = {{W{1'b0}}, pp} << (sh * kmode_pkg::HALF_BITS);
        digit    = kmode_pkg::div_digit({r_rem, r_ma[W-1 -: 4]}, r_d);
    end

    always_comb begin
        qp = (r_p[0] ? kmode_pkg::EXT_BITS'(r_quo) : '0)
           + (r_p[1] ? kmode_pkg::EXT_BITS'({r_quo, 1'b0}) : '0)
           + kmode_pkg::EXT_BITS'(kmode_pkg::round_term(r_rem, r_p, r_d));
        q5 = r_quo + ((r_rem >= R'(3)) ? W'(1) : W'(0));
        case (r_op)
            kmode_pkg::OP_ADD, kmode_pkg::OP_SUB: fin = kmode_pkg::sat_sum(r_sum);
            kmode_pkg::OP_MUL: begin
                if (|r_acc[kmode_pkg::PROD_BITS-1:W+F]) begin
                    fin = r_neg ? kmode_pkg::WMIN : kmode_pkg::WMAX;
                end else begin
                    fin = kmode_pkg::from_mag(r_neg, kmode_pkg::EXT_BITS'(r_acc[W+F-1:F]));
                end
            end
            kmode_pkg::OP_SCL: fin = kmode_pkg::from_mag(r_neg, qp);
            kmode_pkg::OP_FIF: fin = {1'b0, q5[W-2:0]};
            default: fin = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd.start) begin
                        r_cnt <= '0;
                        case (i_cmd.op)
                            kmode_pkg::OP_MUL:                    r_state <= ST_MUL;
                            kmode_pkg::OP_SCL, kmode_pkg::OP_FIF: r_state <= ST_DIV;
                            default:                              r_state <= ST_FIN;
                        endcase
                    end
                end
                ST_MUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd3) r_state <= ST_RND;
                end
                ST_RND: r_state <= ST_FIN;
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'(kmode_pkg::DIV_STEPS - 1)) r_state <= ST_FIN;
                end
                ST_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_op  <= i_cmd.op;
                r_p   <= i_cmd.p;
                r_d   <= i_cmd.d;
                r_neg <= (i_cmd.op == kmode_pkg::OP_MUL) ? (i_opa[W-1] ^ i_opb[W-1])
                                                         : i_opa[W-1];
                r_ma  <= start_ma;
                r_mb  <= kmode_pkg::mag(i_opb);
                r_sum <= (i_cmd.op == kmode_pkg::OP_SUB) ? dif_ab : sum_ab;
                r_acc <= '0;
                r_rem <= '0;
                r_quo <= '0;
            end
            ST_MUL: r_acc <= r_acc + pp_shift;
            ST_RND: r_acc <= r_acc + (kmode_pkg::PROD_BITS'(1) << (F - 1));
            ST_DIV: begin
                r_ma  <= r_ma << 4;
                r_quo <= {r_quo[W-5:0], digit[R+3:R]};
                r_rem <= digit[R-1:0];
            end
            ST_FIN: r_result <= fin;
            default: ;
        endcase
    end

    assign o_sts.busy = (r_state != ST_IDLE);
    assign o_sts.done = r_done;
    assign o_result   = r_result;

endmodule

### hw/rtl/kutta_merson_two_state_ode_step_unit.sv
// kutta_merson_two_state_ode_step_unit: Kutta-Merson step of a two-state boost model
// depends on kmode_pkg, kmode_in_if, kmode_out_if and kmode_alu
//
//  channel   dir  beat content                                           handshake
//  i_item    in   kind, start_time, init_current, init_voltage           valid/ready
//  o_res     out  time_now, current_now, voltage_now, *_error            valid/ready
//  i_cfg_*   in   register index and data, written at once               write enable
//
// a load beat goes straight to the output state; a step beat runs a 94-entry microprogram through
// one shared arithmetic unit, each entry passing in turn through the fetch, operate and wait states
// the sequencer handles one beat at a time; i_item.ready is high only in idle
// a finished result sits in the output register, so the next beat is taken before it drains
// synchronous active-low reset clears control, state words and loads the register defaults
module kutta_merson_two_state_ode_step_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [kmode_pkg::CFG_BITS-1:0]       i_cfg_idx,
    input  logic [kmode_pkg::WORD_BITS-1:0]      i_cfg_data,
    kmode_in_if.sink                             i_item,
    kmode_out_if.source                          o_res
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_OPER  = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam int E = kmode_pkg::ERR_BITS;

    // configuration
    logic [kmode_pkg::STEP_BITS-1:0] r_step;
    kmode_pkg::t_word r_cii, r_civ, r_cib, r_cvi, r_cvv;

    // integrator state
    kmode_pkg::t_word r_time, r_cur, r_vol, r_cci, r_ccv;
    logic [E-1:0]     r_erri, r_errv;

    // sequencer
    logic [2:0]                      r_state;
    logic [kmode_pkg::PC_BITS-1:0]   r_pc;
    kmode_pkg::t_uop                 cur_uop;

    // scratch words of the step, two registered read ports
    kmode_pkg::t_word r_mem [kmode_pkg::TEMP_REGS];
    kmode_pkg::t_word r_rda, r_rdb;

    kmode_pkg::t_word   opa, opb, alu_res;
    kmode_pkg::t_alu_cmd alu_cmd;
    kmode_pkg::t_alu_sts alu_sts;
    logic               wr_en, in_acc, out_load;

    // result register
    logic             r_ov;
    kmode_pkg::t_word r_o_time, r_o_cur, r_o_vol;
    logic [E-1:0]     r_o_erri, r_o_errv;

    assign cur_uop = kmode_pkg::prog_rom(r_pc);
    assign in_acc  = i_item.valid && i_item.ready;
    assign wr_en   = (r_state == S_WAIT) && alu_sts.done;
    assign out_load = (r_state == S_OUT) && (!r_ov || o_res.ready);

    // named operand selects, scratch entries otherwise
    always_comb begin
        case (cur_uop.sa)
            kmode_pkg::R_H:   opa = {1'b0, r_step};
            kmode_pkg::R_CII: opa = r_cii;
            kmode_pkg::R_CIV: opa = r_civ;
            kmode_pkg::R_CIB: opa = r_cib;
            kmode_pkg::R_CVI: opa = r_cvi;
            kmode_pkg::R_CVV: opa = r_cvv;
            kmode_pkg::R_CUR: opa = r_cur;
            kmode_pkg::R_VOL: opa = r_vol;
            kmode_pkg::R_CCI: opa = r_cci;
            kmode_pkg::R_CCV: opa = r_ccv;
            kmode_pkg::R_TIM: opa = r_time;
            default:          opa = r_rda;
        endcase
        case (cur_uop.sb)
            kmode_pkg::R_H:   opb = {1'b0, r_step};
            kmode_pkg::R_CII: opb = r_cii;
            kmode_pkg::R_CIV: opb = r_civ;
            kmode_pkg::R_CIB: opb = r_cib;
            kmode_pkg::R_CVI: opb = r_cvi;
            kmode_pkg::R_CVV: opb = r_cvv;
            kmode_pkg::R_CUR: opb = r_cur;
            kmode_pkg::R_VOL: opb = r_vol;
            kmode_pkg::R_CCI: opb = r_cci;
            kmode_pkg::R_CCV: opb = r_ccv;
            kmode_pkg::R_TIM: opb = r_time;
            default:          opb = r_rdb;
        endcase
    end

    always_comb begin
        alu_cmd.start = (r_state == S_OPER);
        alu_cmd.op    = cur_uop.op;
        alu_cmd.p     = cur_uop.p;
        alu_cmd.d     = cur_uop.d;
    end

    kmode_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (alu_cmd),
        .i_opa    (opa),
        .i_opb    (opb),
        .o_sts    (alu_sts),
        .o_result (alu_res)
    );

    // scratch memory
    always_ff @(posedge i_clk) begin
        if (wr_en && !cur_uop.dst[kmode_pkg::SEL_BITS-1]) begin
            r_mem[cur_uop.dst[kmode_pkg::TEMP_BITS-1:0]] <= alu_res;
        end
        r_rda <= r_mem[cur_uop.sa[kmode_pkg::TEMP_BITS-1:0]];
        r_rdb <= r_mem[cur_uop.sb[kmode_pkg::TEMP_BITS-1:0]];
    end

    // configuration writes, index beyond the list ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= kmode_pkg::RST_STEP;
            r_cii  <= kmode_pkg::RST_CII;
            r_civ  <= kmode_pkg::RST_CIV;
            r_cib  <= kmode_pkg::RST_CIB;
            r_cvi  <= kmode_pkg::RST_CVI;
            r_cvv  <= kmode_pkg::RST_CVV;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kmode_pkg::CFG_STEP: r_step <= i_cfg_data[kmode_pkg::STEP_BITS-1:0];
                kmode_pkg::CFG_CII:  r_cii  <= i_cfg_data;
                kmode_pkg::CFG_CIV:  r_civ  <= i_cfg_data;
                kmode_pkg::CFG_CIB:  r_cib  <= i_cfg_data;
                kmode_pkg::CFG_CVI:  r_cvi  <= i_cfg_data;
                kmode_pkg::CFG_CVV:  r_cvv  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and state words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_time  <= '0;
            r_cur   <= '0;
            r_vol   <= '0;
            r_cci   <= '0;
            r_ccv   <= '0;
            r_erri  <= '0;
            r_errv  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_item.kind == kmode_pkg::KIND_LOAD) begin
                            r_time  <= i_item.start_time;
                            r_cur   <= i_item.init_current;
                            r_vol   <= i_item.init_voltage;
                            r_cci   <= i_item.init_current;
                            r_ccv   <= i_item.init_voltage;
                            r_erri  <= '0;
                            r_errv  <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_pc    <= '0;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: r_state <= S_OPER;
                S_OPER:  r_state <= S_WAIT;
                S_WAIT: begin
                    if (alu_sts.done) begin
                        case (cur_uop.dst)
                            kmode_pkg::R_CUR: r_cur  <= alu_res;
                            kmode_pkg::R_VOL: r_vol  <= alu_res;
                            kmode_pkg::R_CCI: r_cci  <= alu_res;
                            kmode_pkg::R_CCV: r_ccv  <= alu_res;
                            kmode_pkg::R_TIM: r_time <= alu_res;
                            kmode_pkg::R_EI:  r_erri <= alu_res[E-1:0];
                            kmode_pkg::R_EV:  r_errv <= alu_res[E-1:0];
                            default: ;
                        endcase
                        if (r_pc == kmode_pkg::PROG_LAST) begin
                            r_state <= S_OUT;
                        end else begin
                            r_pc    <= r_pc + 1'b1;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_OUT: begin
                    if (out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register, holds until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_time <= r_time;
            r_o_cur  <= r_cur;
            r_o_vol  <= r_vol;
            r_o_erri <= r_erri;
            r_o_errv <= r_errv;
        end
    end

    assign i_item.ready        = (r_state == S_IDLE);
    assign o_res.valid         = r_ov;
    assign o_res.time_now      = r_o_time;
    assign o_res.current_now   = r_o_cur;
    assign o_res.voltage_now   = r_o_vol;
    assign o_res.current_error = r_o_erri;
    assign o_res.voltage_error = r_o_errv;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_sts.done |-> (r_state == S_WAIT))
        else $error("arithmetic result outside wait state");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= kmode_pkg::PROG_LAST)
        else $error("program counter past last entry");

    a_step_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_item.kind == kmode_pkg::KIND_STEP) |=> (r_state == S_FETCH && r_pc == '0))
        else $error("step beat did not start the program");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> ($past(r_state) == S_OUT))
        else $error("result beat raised outside output state");

    a_busy_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_sts.busy |-> (r_state == S_WAIT))
        else $error("arithmetic unit busy while sequencer not waiting");

endmodule

### tb/sv/kutta_merson_two_state_ode_step_unit_tb.sv
// kutta_merson_two_state_ode_step_unit_tb: self-checking bench for the Kutta-Merson step unit,
// with its own saturating fixed-point predictor of the load and step beats
// depends on kmode_pkg, kmode_in_if, kmode_out_if and the unit under test
module kutta_merson_two_state_ode_step_unit_tb;
    import kmode_pkg::*;

    typedef logic signed [WORD_BITS-1:0] t_fix;
    typedef logic signed [129:0]         t_wide_s;
    typedef logic [129:0]                t_wide_u;

    typedef struct packed {
        t_fix                time_now;
        t_fix                current_now;
        t_fix                voltage_now;
        logic [ERR_BITS-1:0] current_error;
        logic [ERR_BITS-1:0] voltage_error;
    } t_solution;

    localparam t_fix            FIX_MAX  = 64'sh7fff_ffff_ffff_ffff;
    localparam t_fix            FIX_MIN  = 64'sh8000_0000_0000_0000;
    localparam t_wide_u         MAG_MAX  = 130'h7fff_ffff_ffff_ffff;
    localparam t_wide_u         MAG_NEG  = 130'h8000_0000_0000_0000;
    localparam t_wide_s         WIDE_MAX = 130'sh7fff_ffff_ffff_ffff;
    localparam t_wide_s         WIDE_MIN = -130'sh8000_0000_0000_0000;
    localparam logic [CFG_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_BITS-1:0] CFG_SPARE_HI = 3'd7;
    localparam int              CYCLE_LIMIT   = 6000000;
    localparam int              IDLE_SETTLE   = 20;
    localparam int              RANDOM_ITEMS  = 1400;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_BITS-1:0]  i_cfg_idx;
    logic [WORD_BITS-1:0] i_cfg_data;

    kmode_in_if  item_ch ();
    kmode_out_if res_ch ();

    kutta_merson_two_state_ode_step_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_item    (item_ch),
        .o_res     (res_ch)
    );

    // predictor copy of registers and integrator state
    logic [STEP_BITS-1:0] mdl_step;
    t_fix mdl_cii, mdl_civ, mdl_cib, mdl_cvi, mdl_cvv;
    t_fix mdl_time, mdl_cur, mdl_vol, mdl_comp_cur, mdl_comp_vol;

    t_solution pending_solutions[$];
    int        fail_count;
    int        cycle_count;
    bit        quiet_send;   // sender never idles while set
    bit        quiet_recv;   // receiver never stalls while set

    always #5 i_clk = ~i_clk;

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- fixed-point arithmetic of the predictor ----------------

    function automatic t_fix clamp_wide(input t_wide_s x);
        if (x > WIDE_MAX) return FIX_MAX;
        if (x < WIDE_MIN) return FIX_MIN;
        return x[WORD_BITS-1:0];
    endfunction

    function automatic t_wide_u magnitude(input t_fix x);
        t_wide_u r;
        r = x;
        if (x < 0) r = -r;
        return r;
    endfunction

    // signed word from sign and magnitude, saturated
    function automatic t_fix signed_from(input logic neg, input t_wide_u m);
        t_wide_u n;
        if (!neg) return (m > MAG_MAX) ? FIX_MAX : m[WORD_BITS-1:0];
        if (m == 0) return '0;
        if (m > MAG_NEG) return FIX_MIN;
        n = -m;
        return n[WORD_BITS-1:0];
    endfunction

    function automatic t_fix sat_add(input t_fix a, input t_fix b);
        t_wide_s wa, wb;
        wa = a;
        wb = b;
        return clamp_wide(wa + wb);
    endfunction

    function automatic t_fix sat_sub(input t_fix a, input t_fix b);
        t_wide_s wa, wb;
        wa = a;
        wb = b;
        return clamp_wide(wa - wb);
    endfunction

    // Q24.40 product, round half away from zero
    function automatic t_fix fix_mul(input t_fix a, input t_fix b);
        t_wide_u p;
        p = magnitude(a) * magnitude(b);
        p = p + (t_wide_u'(1) << (FRAC_BITS - 1));
        return signed_from(a[WORD_BITS-1] ^ b[WORD_BITS-1], p >> FRAC_BITS);
    endfunction

    // x * num / den, round half away from zero
    function automatic t_fix fix_scale(input t_fix x, input int num, input int den);
        t_wide_u m;
        m = magnitude(x);
        m = (m * 2 * num + den) / (2 * den);
        return signed_from(x[WORD_BITS-1], m);
    endfunction

    function automatic logic [ERR_BITS-1:0] fifth_gap(input t_fix a, input t_fix b);
        t_wide_s d;
        t_wide_u m;
        d = a;
        d = d - b;
        if (d < 0) d = -d;
        m = d;
        m = (2 * m + 5) / 10;
        return m[ERR_BITS-1:0];
    endfunction

    function automatic t_fix slope_cur(input t_fix x, input t_fix y);
        return sat_add(sat_add(fix_mul(mdl_cii, x), fix_mul(mdl_civ, y)), mdl_cib);
    endfunction

    function automatic t_fix slope_vol(input t_fix x, input t_fix y);
        return sat_add(fix_mul(mdl_cvi, x), fix_mul(mdl_cvv, y));
    endfunction

    function automatic void reset_predictor();
        mdl_step = RST_STEP;
        mdl_cii  = RST_CII;
        mdl_civ  = RST_CIV;
        mdl_cib  = RST_CIB;
        mdl_cvi  = RST_CVI;
        mdl_cvv  = RST_CVV;
        mdl_time = '0;
        mdl_cur  = '0;
        mdl_vol  = '0;
        mdl_comp_cur = '0;
        mdl_comp_vol = '0;
    endfunction

    // one Kutta-Merson step or load, returns the solution beat it yields
    function automatic t_solution integrate(input logic kind, input t_fix t0, input t_fix c0,
                                            input t_fix v0);
        t_solution s;
        t_fix h, w, z, k1, l1, k2, l2, k3, l3, k4, l4, k5, l5, wi, zi, dw, dz;
        s.current_error = '0;
        s.voltage_error = '0;
        if (kind == KIND_LOAD) begin
            mdl_time = t0;
            mdl_cur  = c0;
            mdl_vol  = v0;
            mdl_comp_cur = c0;
            mdl_comp_vol = v0;
        end else begin
            h = {1'b0, mdl_step};
            w = mdl_cur;
            z = mdl_vol;
            k1 = fix_mul(h, slope_cur(w, z));
            l1 = fix_mul(h, slope_vol(w, z));
            wi = sat_add(w, fix_scale(k1, 1, 3));
            zi = sat_add(z, fix_scale(l1, 1, 3));
            k2 = fix_mul(h, slope_cur(wi, zi));
            l2 = fix_mul(h, slope_vol(wi, zi));
            wi = sat_add(sat_add(w, fix_scale(k1, 1, 6)), fix_scale(k2, 1, 6));
            zi = sat_add(sat_add(z, fix_scale(l1, 1, 6)), fix_scale(l2, 1, 6));
            k3 = fix_mul(h, slope_cur(wi, zi));
            l3 = fix_mul(h, slope_vol(wi, zi));
            wi = sat_add(sat_add(w, fix_scale(k1, 1, 8)), fix_scale(k3, 3, 8));
            zi = sat_add(sat_add(z, fix_scale(l1, 1, 8)), fix_scale(l3, 3, 8));
            k4 = fix_mul(h, slope_cur(wi, zi));
            l4 = fix_mul(h, slope_vol(wi, zi));
            // companion increment, reused as the fifth-stage abscissa
            dw = sat_add(sat_add(sat_sub(fix_scale(k1, 1, 2), fix_scale(k3, 3, 2)), k4), k4);
            dz = sat_add(sat_add(sat_sub(fix_scale(l1, 1, 2), fix_scale(l3, 3, 2)), l4), l4);
            wi = sat_add(w, dw);
            zi = sat_add(z, dz);
            k5 = fix_mul(h, slope_cur(wi, zi));
            l5 = fix_mul(h, slope_vol(wi, zi));
            mdl_cur = sat_add(w, sat_add(sat_add(fix_scale(k1, 1, 6), fix_scale(k4, 2, 3)),
                                         fix_scale(k5, 1, 6)));
            mdl_vol = sat_add(z, sat_add(sat_add(fix_scale(l1, 1, 6), fix_scale(l4, 2, 3)),
                                         fix_scale(l5, 1, 6)));
            mdl_comp_cur = sat_add(mdl_comp_cur, dw);
            mdl_comp_vol = sat_add(mdl_comp_vol, dz);
            mdl_time = sat_add(mdl_time, h);
            s.current_error = fifth_gap(mdl_comp_cur, mdl_cur);
            s.voltage_error = fifth_gap(mdl_comp_vol, mdl_vol);
        end
        s.time_now    = mdl_time;
        s.current_now = mdl_cur;
        s.voltage_now = mdl_vol;
        return s;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic t_fix any_word();
        return {$urandom, $urandom};
    endfunction

    // state values: mostly plausible magnitudes, some full range
    function automatic t_fix state_value();
        t_fix v;
        v = any_word();
        case ($urandom_range(0, 7))
            0, 1:    ;
            2:       v = $urandom_range(0, 1) ? FIX_MAX : FIX_MIN;
            default: v = v >>> $urandom_range(14, 40);
        endcase
        return v;
    endfunction

    function automatic t_fix coef_value();
        t_fix v;
        v = any_word();
        case ($urandom_range(0, 9))
            0:       ;
            1:       v = FIX_MAX;
            2:       v = FIX_MIN;
            3:       v = '0;
            default: v = v >>> $urandom_range(8, 30);
        endcase
        return v;
    endfunction

    // hold the sender until every solution beat is back
    task automatic drain();
        item_ch.valid = 1'b0;
        while (pending_solutions.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_BITS-1:0] idx, input logic [WORD_BITS-1:0] data);
        drain();
        repeat (IDLE_SETTLE) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            CFG_STEP: mdl_step = data[STEP_BITS-1:0];
            CFG_CII:  mdl_cii  = data;
            CFG_CIV:  mdl_civ  = data;
            CFG_CIB:  mdl_cib  = data;
            CFG_CVI:  mdl_cvi  = data;
            CFG_CVV:  mdl_cvv  = data;
            default:  ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all(input logic [WORD_BITS-1:0] h, input t_fix cii, input t_fix civ,
                             input t_fix cib, input t_fix cvi, input t_fix cvv);
        write_reg(CFG_STEP, h);
        write_reg(CFG_CII, cii);
        write_reg(CFG_CIV, civ);
        write_reg(CFG_CIB, cib);
        write_reg(CFG_CVI, cvi);
        write_reg(CFG_CVV, cvv);
    endtask

    // sends one beat, entered and left at a falling edge
    task automatic send_item(input logic kind, input t_fix t0, input t_fix c0, input t_fix v0);
        int gap;
        gap = draw_wait(quiet_send);
        if (gap > 0) begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.kind         = kind;
        item_ch.start_time   = t0;
        item_ch.init_current = c0;
        item_ch.init_voltage = v0;
        item_ch.valid        = 1'b1;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        pending_solutions.push_back(integrate(kind, t0, c0, v0));
        @(negedge i_clk);
    endtask

    task automatic send_step();
        send_item(KIND_STEP, any_word(), any_word(), any_word());
    endtask

    // ---------------- result checking ----------------

    initial begin
        t_solution want;
        int        stall;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = draw_wait(quiet_recv);
            if (stall > 0) begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            if (pending_solutions.size() == 0) begin
                $display("%0t: solution beat with none expected", $time);
                fail_count++;
            end else begin
                want = pending_solutions.pop_front();
                if (res_ch.time_now !== want.time_now) begin
                    $display("%0t: time_now exp %h got %h", $time, want.time_now,
                             res_ch.time_now);
                    fail_count++;
                end
                if (res_ch.current_now !== want.current_now) begin
                    $display("%0t: current_now exp %h got %h", $time, want.current_now,
                             res_ch.current_now);
                    fail_count++;
                end
                if (res_ch.voltage_now !== want.voltage_now) begin
                    $display("%0t: voltage_now exp %h got %h", $time, want.voltage_now,
                             res_ch.voltage_now);
                    fail_count++;
                end
                if (res_ch.current_error !== want.current_error) begin
                    $display("%0t: current_error exp %h got %h", $time, want.current_error,
                             res_ch.current_error);
                    fail_count++;
                end
                if (res_ch.voltage_error !== want.voltage_error) begin
                    $display("%0t: voltage_error exp %h got %h", $time, want.voltage_error,
                             res_ch.voltage_error);
                    fail_count++;
                end
            end
        end
    end

    // ---------------- tests ----------------

    // extremes of the load fields, a step before any load, default model trajectory
    task automatic test_directed();
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
        send_step();
        send_item(KIND_LOAD, '0, '0, '0);
        send_step();
        send_step();
        send_item(KIND_LOAD, FIX_MAX, FIX_MAX, FIX_MAX);
        send_step();
        send_item(KIND_LOAD, FIX_MIN, FIX_MIN, FIX_MIN);
        send_step();
        send_item(KIND_LOAD, -64'sd1, 64'sd1, -64'sd1);
        send_step();
        // realistic operating point: 2 A, 40 V
        send_item(KIND_LOAD, 64'sd0, 64'sd2199023255552, 64'sd43980465111040);
        repeat (4) send_step();
    endtask

    // zero step keeps state, saturating coefficients drive every clamp
    task automatic test_register_extremes();
        write_reg(CFG_STEP, '0);
        send_item(KIND_LOAD, 64'sd5, 64'sd1099511627776, -64'sd1099511627776);
        send_step();
        send_step();
        write_all({1'b0, {(STEP_BITS){1'b1}}}, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX);
        send_item(KIND_LOAD, FIX_MAX - 64'sd3, 64'sd1099511627776, -64'sd1099511627776);
        send_step();
        send_step();
        write_all({1'b1, {(STEP_BITS){1'b1}}}, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN);
        send_item(KIND_LOAD, '0, 64'sd3, -64'sd3);
        send_step();
        // spare indexes must leave every register alone
        write_reg(CFG_SPARE_LO, '0);
        write_reg(CFG_SPARE_HI, '1);
        send_step();
        write_all(RST_STEP, RST_CII, RST_CIV, RST_CIB, RST_CVI, RST_CVV);
    endtask

    // loads followed by runs of steps, with some bare noise beats, under random or default settings
    task automatic test_random_trajectories();
        int sent;
        int seg;
        int run;
        sent = 0;
        seg  = 0;
        while (sent < RANDOM_ITEMS) begin
            if (seg % 3 == 0) begin
                write_all(RST_STEP, RST_CII, RST_CIV, RST_CIB, RST_CVI, RST_CVV);
            end else begin
                write_all($urandom_range(0, 9) == 0 ? {$urandom, $urandom} :
                          64'(1) << $urandom_range(8, 38),
                          coef_value(), coef_value(), coef_value(), coef_value(),
                          coef_value());
            end
            quiet_send = ($urandom_range(0, 3) == 0);
            quiet_recv = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 200 && sent < RANDOM_ITEMS; n++) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_item($urandom_range(0, 1), any_word(), any_word(), any_word());
                    sent++;
                end else begin
                    send_item(KIND_LOAD, state_value(), state_value(), state_value());
                    sent++;
                    run = $urandom_range(1, 12);
                    repeat (run) send_step();
                    sent += run;
                end
            end
            seg++;
        end
    endtask

    // sender holds off until the pipeline is empty, then a back-to-back burst
    task automatic test_drain_pause();
        quiet_send = 1'b1;
        quiet_recv = 1'b0;
        send_item(KIND_LOAD, state_value(), state_value(), state_value());
        send_step();
        drain();
        repeat (5) send_step();
        quiet_send = 1'b0;
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_STEP;
        i_cfg_data  = '0;
        item_ch.valid        = 1'b0;
        item_ch.kind         = KIND_LOAD;
        item_ch.start_time   = '0;
        item_ch.init_current = '0;
        item_ch.init_voltage = '0;
        fail_count  = 0;
        cycle_count = 0;
        quiet_send  = 1'b0;
        quiet_recv  = 1'b0;
        reset_predictor();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_register_extremes();
        test_drain_pause();
        test_random_trajectories();

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
